// ----- hdl/hca_pkg.sv -----
package hca_pkg;

  localparam int POS_BITS = 32;
  localparam int PROD_BITS = 48;
  localparam int CMP_BITS = (POS_BITS > PROD_BITS) ? POS_BITS : PROD_BITS;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic                sig_flag;
    logic                unfinished;
    logic [POS_BITS-1:0] pos;
    logic [15:0]         ver;
    logic [15:0]         offs;
    logic [31:0]         format;
    logic [31:0]         blocks;
    logic [15:0]         bsize;
    logic [31:0]         lstart;
    logic [31:0]         lend;
    logic [31:0]         vol;
  } hca_snap_t;

endpackage

// ----- hdl/hca_parser.sv -----
module hca_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         data_byte,
  input  logic               is_last,
  output logic               snap_valid,
  input  logic               snap_ready,
  output hca_pkg::hca_snap_t snap
);
  import hca_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_VER,
    PH_OFFS,
    PH_TAG,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_FMT,
    K_DEC,
    K_RVA,
    K_ATH,
    K_LOOP,
    K_CIPH
  } kind_t;

  localparam logic [31:0] SIGN_MASK = 32'h7F7F7F7F;
  localparam logic [31:0] TAG_HCA = 32'h48434100;
  localparam logic [31:0] TAG_FMT = 32'h666D7400;
  localparam logic [31:0] TAG_DEC = 32'h64656300;
  localparam logic [31:0] TAG_RVA = 32'h72766100;
  localparam logic [31:0] TAG_ATH = 32'h61746800;
  localparam logic [31:0] TAG_LOOP = 32'h6C6F6F70;
  localparam logic [31:0] TAG_CIPH = 32'h63697068;
  localparam logic [31:0] TAG_PAD = 32'h70616400;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic [POS_BITS-1:0] pos, pos_next;
  phase_t              phase, phase_next;
  logic [31:0]         shifter, shifter_next;
  logic [3:0]          idx, idx_next;
  kind_t               kind, kind_next;
  logic                finished, finished_next;
  logic                sig_bad, sig_bad_next;
  logic [15:0]         ver, ver_next;
  logic [15:0]         offs, offs_next;
  logic [31:0]         format, format_next;
  logic [31:0]         blocks, blocks_next;
  logic [15:0]         bsize, bsize_next;
  logic [31:0]         lstart, lstart_next;
  logic [31:0]         lend, lend_next;
  logic [31:0]         vol, vol_next;

  logic [31:0] shift_in;
  logic [31:0] masked;
  logic [3:0]  idx_inc;
  logic [3:0]  body_end;
  logic [15:0] bound_offs;
  logic        at_bound;
  logic        byte_accept;

  assign byte_stall = snap_valid && !snap_ready;
  assign byte_accept = byte_valid && !byte_stall;

  always_comb begin
    pos_next = (pos == POS_MAX) ? pos : pos + 1'b1;
    phase_next = phase;
    shifter_next = shifter;
    idx_next = idx;
    kind_next = kind;
    finished_next = finished;
    sig_bad_next = sig_bad;
    ver_next = ver;
    offs_next = offs;
    format_next = format;
    blocks_next = blocks;
    bsize_next = bsize;
    lstart_next = lstart;
    lend_next = lend;
    vol_next = vol;
    shift_in = {shifter[23:0], data_byte};
    masked = shift_in & SIGN_MASK;
    idx_inc = idx + 4'd1;
    bound_offs = offs;
    at_bound = 1'b0;
    case (kind)
      K_FMT, K_LOOP: body_end = 4'd12;
      K_DEC: body_end = 4'd8;
      K_RVA: body_end = 4'd4;
      default: body_end = 4'd2;
    endcase
    if (phase != PH_DONE) begin
      shifter_next = shift_in;
      idx_next = idx_inc;
      case (phase)
        PH_SIG: begin
          if (idx_inc == 4'd4) begin
            idx_next = 4'd0;
            if (masked != TAG_HCA) begin
              sig_bad_next = 1'b1;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_VER;
            end
          end
        end
        PH_VER: begin
          if (idx_inc == 4'd2) begin
            ver_next = shift_in[15:0];
            idx_next = 4'd0;
            phase_next = PH_OFFS;
          end
        end
        PH_OFFS: begin
          if (idx_inc == 4'd2) begin
            offs_next = shift_in[15:0];
            bound_offs = shift_in[15:0];
            at_bound = 1'b1;
          end
        end
        PH_TAG: begin
          if (idx_inc == 4'd4) begin
            idx_next = 4'd0;
            phase_next = PH_BODY;
            if (masked == TAG_FMT) begin
              kind_next = K_FMT;
            end else if (masked == TAG_DEC) begin
              kind_next = K_DEC;
            end else if (masked == TAG_RVA) begin
              kind_next = K_RVA;
            end else if (masked == TAG_ATH) begin
              kind_next = K_ATH;
            end else if (masked == TAG_LOOP) begin
              kind_next = K_LOOP;
            end else if (masked == TAG_CIPH) begin
              kind_next = K_CIPH;
            end else if (masked == TAG_PAD) begin
              at_bound = 1'b1;
            end else begin
              phase_next = PH_DONE;
              finished_next = 1'b1;
            end
          end
        end
        PH_BODY: begin
          case (kind)
            K_FMT: begin
              if (idx_inc == 4'd4) format_next = shift_in;
              if (idx_inc == 4'd8) blocks_next = shift_in;
            end
            K_DEC: begin
              if (idx_inc == 4'd2) bsize_next = shift_in[15:0];
            end
            K_RVA: begin
              if (idx_inc == 4'd4) vol_next = shift_in;
            end
            K_LOOP: begin
              if (idx_inc == 4'd4) lstart_next = shift_in;
              if (idx_inc == 4'd8) lend_next = shift_in + 32'd1;
            end
            default: begin
            end
          endcase
          if (idx_inc >= body_end) at_bound = 1'b1;
        end
        default: begin
        end
      endcase
      if (at_bound) begin
        idx_next = 4'd0;
        kind_next = K_NONE;
        if (pos_next < POS_BITS'(bound_offs)) begin
          phase_next = PH_TAG;
        end else begin
          phase_next = PH_DONE;
          finished_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      phase <= PH_SIG;
      shifter <= '0;
      idx <= '0;
      kind <= K_NONE;
      finished <= 1'b0;
      sig_bad <= 1'b0;
      ver <= '0;
      offs <= '0;
      format <= '0;
      blocks <= '0;
      bsize <= '0;
      lstart <= '0;
      lend <= '0;
      vol <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (byte_accept && is_last) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (byte_accept) begin
        if (is_last) begin
          snap.sig_flag <= sig_bad_next || (phase_next == PH_SIG);
          snap.unfinished <= !finished_next;
          snap.pos <= pos_next;
          snap.ver <= ver_next;
          snap.offs <= offs_next;
          snap.format <= format_next;
          snap.blocks <= blocks_next;
          snap.bsize <= bsize_next;
          snap.lstart <= lstart_next;
          snap.lend <= lend_next;
          snap.vol <= vol_next;
          pos <= '0;
          phase <= PH_SIG;
          shifter <= '0;
          idx <= '0;
          kind <= K_NONE;
          finished <= 1'b0;
          sig_bad <= 1'b0;
          ver <= '0;
          offs <= '0;
          format <= '0;
          blocks <= '0;
          bsize <= '0;
          lstart <= '0;
          lend <= '0;
          vol <= '0;
        end else begin
          pos <= pos_next;
          phase <= phase_next;
          shifter <= shifter_next;
          idx <= idx_next;
          kind <= kind_next;
          finished <= finished_next;
          sig_bad <= sig_bad_next;
          ver <= ver_next;
          offs <= offs_next;
          format <= format_next;
          blocks <= blocks_next;
          bsize <= bsize_next;
          lstart <= lstart_next;
          lend <= lend_next;
          vol <= vol_next;
        end
      end
    end
  end

endmodule

// ----- hdl/hca_check.sv -----
module hca_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               snap_valid,
  output logic               snap_ready,
  input  hca_pkg::hca_snap_t snap,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [15:0]        format_version,
  output logic [1:0]         channel_count,
  output logic [23:0]        sample_rate,
  output logic [31:0]        blocks_total,
  output logic [15:0]        bytes_per_block,
  output logic [31:0]        loop_first,
  output logic [31:0]        loop_past_end,
  output logic [31:0]        volume_bits,
  output logic [15:0]        payload_start
);
  import hca_pkg::*;

  logic                 mid_valid;
  logic                 mid_sig_flag;
  logic                 mid_unfinished;
  logic [POS_BITS-1:0]  mid_pos;
  logic [PROD_BITS-1:0] mid_dsize;
  logic [15:0]          mid_ver;
  logic [1:0]           mid_ch;
  logic [23:0]          mid_rate;
  logic [31:0]          mid_blocks;
  logic [15:0]          mid_bsize;
  logic [31:0]          mid_lstart;
  logic [31:0]          mid_lend;
  logic [31:0]          mid_vol;
  logic [15:0]          mid_offs;

  logic                 mid_ready;
  logic                 out_load;
  logic [PROD_BITS-1:0] product;
  logic [1:0]           ch_clamp;
  logic [CMP_BITS:0]    need;
  logic [1:0]           status_next;

  assign out_load = mid_valid && (!result_valid || !result_stall);
  assign mid_ready = !mid_valid || out_load;
  assign snap_ready = mid_ready;

  assign product = snap.blocks * snap.bsize;
  assign ch_clamp = (snap.format[31:24] > 8'd2) ? 2'd2 : snap.format[25:24];
  assign need = (CMP_BITS + 1)'(mid_offs) + (CMP_BITS + 1)'(mid_dsize);

  always_comb begin
    if (mid_sig_flag) begin
      status_next = ST_BAD_SIG;
    end else if (mid_unfinished) begin
      status_next = ST_TRUNC;
    end else if (mid_dsize == '0) begin
      status_next = ST_EMPTY;
    end else if ((CMP_BITS + 1)'(mid_pos) < need) begin
      status_next = ST_TRUNC;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (snap_valid && mid_ready) begin
        mid_valid <= 1'b1;
      end else if (out_load) begin
        mid_valid <= 1'b0;
      end
    end
    if (snap_valid && mid_ready) begin
      mid_sig_flag <= snap.sig_flag;
      mid_unfinished <= snap.unfinished;
      mid_pos <= snap.pos;
      mid_dsize <= product;
      mid_ver <= snap.ver;
      mid_ch <= ch_clamp;
      mid_rate <= snap.format[23:0];
      mid_blocks <= snap.blocks;
      mid_bsize <= snap.bsize;
      mid_lstart <= snap.lstart;
      mid_lend <= (snap.lend == 32'd0) ? snap.blocks : snap.lend;
      mid_vol <= snap.vol;
      mid_offs <= snap.offs;
    end
    if (out_load) begin
      status <= status_next;
      format_version <= mid_ver;
      channel_count <= mid_ch;
      sample_rate <= mid_rate;
      blocks_total <= mid_blocks;
      bytes_per_block <= mid_bsize;
      loop_first <= mid_lstart;
      loop_past_end <= mid_lend;
      volume_bits <= mid_vol;
      payload_start <= mid_offs;
    end
  end

endmodule

// ----- hdl/hca_header_parser.sv -----
// Header parser for an audio file that arrives as a stream of byte beats.
// The byte channel (byte_valid, byte_stall, data_byte, is_last) carries one
// file byte per beat; is_last marks the final byte of a file. The result
// channel (result_valid, result_stall and the field ports) carries one beat
// per file with the captured header fields and a status code.
// A byte beat is taken in every cycle in which byte_valid is high and byte_stall is low.
// Each accepted byte updates the registered parser state; no loop spans bytes.
// The result passes three registers after its last byte: a snapshot of the
// captured fields, the registered block-count by block-size product, and
// the output register where the payload size check sets the status.
// The next file may begin right after a last byte unless byte_stall holds it.
// While the receiver stalls, the result holds on the outputs, and the two
// stages behind it fill; byte_stall rises only when a last byte's snapshot
// cannot move on, so bytes that are not last keep flowing until then.
// A synchronous reset clears the parser to expect a signature and empties
// all result stages; rst is active high.
module hca_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [15:0] format_version,
  output logic [1:0]  channel_count,
  output logic [23:0] sample_rate,
  output logic [31:0] blocks_total,
  output logic [15:0] bytes_per_block,
  output logic [31:0] loop_first,
  output logic [31:0] loop_past_end,
  output logic [31:0] volume_bits,
  output logic [15:0] payload_start
);
  import hca_pkg::*;

  logic      snap_valid;
  logic      snap_ready;
  hca_snap_t snap;

  hca_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .is_last    (is_last),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  hca_check u_check (
    .clk             (clk),
    .rst             (rst),
    .snap_valid      (snap_valid),
    .snap_ready      (snap_ready),
    .snap            (snap),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .status          (status),
    .format_version  (format_version),
    .channel_count   (channel_count),
    .sample_rate     (sample_rate),
    .blocks_total    (blocks_total),
    .bytes_per_block (bytes_per_block),
    .loop_first      (loop_first),
    .loop_past_end   (loop_past_end),
    .volume_bits     (volume_bits),
    .payload_start   (payload_start)
  );

endmodule
